@@ sv/query_command_parser_macros.svh @@
// assertion macros for the query command parser
// used by the top level; needs a clock and an active-high reset from the caller
`ifndef QUERY_COMMAND_PARSER_MACROS_SVH
`define QUERY_COMMAND_PARSER_MACROS_SVH

// condition holds at every clock edge outside reset
`define QCP_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("qcp invariant violated");

// consequence holds in the cycle after the antecedent
`define QCP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("qcp sequence violated");

`endif

@@ sv/qcp_pkg.sv @@
// shared types and constants of the query command parser
// no dependencies; used by every module of the block but the queue
`default_nettype none

package qcp_pkg;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_QUOTE   = 8'h22;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_BSLASH  = 8'h5C;

   // command words, first letter in the low byte
   localparam logic [47:0] WORD_SEARCH = 48'h686372616573;
   localparam logic [47:0] WORD_INSERT = 48'h747265736E69;
   localparam logic [47:0] WORD_DELETE = 48'h6574656C6564;
   localparam logic [47:0] WORD_QUIT   = 48'h000074697571;

   localparam logic [63:0] KEY_LIMIT_DIV = 64'd1844674407370955161;

   typedef enum logic [2:0] {
      EVT_NONE = 3'd0,
      EVT_CMD  = 3'd1,
      EVT_KEY  = 3'd2,
      EVT_BYTE = 3'd3,
      EVT_PEND = 3'd4
   } evt_type;

   typedef enum logic [1:0] {
      CMD_SEARCH = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_DELETE = 2'd2,
      CMD_QUIT   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      PH_EXP_CMD = 3'd0,
      PH_RD_CMD  = 3'd1,
      PH_EXP_KEY = 3'd2,
      PH_RD_KEY  = 3'd3,
      PH_EXP_PAY = 3'd4,
      PH_RD_PAY  = 3'd5
   } phase_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       end_of_query;
   } req_type;

   typedef struct packed {
      evt_type     event_res;
      cmd_type     cmd;
      logic [63:0] key_value;
      logic [7:0]  data_byte;
      logic        done_res;
      logic        accepted;
   } rsp_type;

   // classified byte passed from front to back
   typedef struct packed {
      logic [7:0] ch;
      logic       last;
      logic       is_letter;
      logic       is_digit;
      logic       is_space;
      logic       is_newline;
      logic       is_semi;
      logic       is_quote;
      logic       is_bslash;
      logic [7:0] lower;
      logic [3:0] digit;
   } tok_type;

endpackage

`default_nettype wire

@@ sv/qcp_queue.sv @@
// small register queue with push/full and pop/empty sides
// generic width and depth; no package dependency
`default_nettype none

module qcp_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

@@ sv/qcp_front.sv @@
// front end: accepts query bytes and classifies them into tokens
// depends on qcp_pkg; feeds the token queue
`default_nettype none

module qcp_front (
   input  wire logic             req_push,
   input  wire qcp_pkg::req_type req_data,
   output logic                  req_full,
   input  wire logic             tok_full,
   output logic                  tok_push,
   output qcp_pkg::tok_type      tok
);

   logic [7:0] ch;
   logic       is_upper;
   logic       is_lower;

   assign ch       = req_data.ch;
   assign is_upper = ch inside {[8'h41:8'h5A]};
   assign is_lower = ch inside {[8'h61:8'h7A]};
   assign req_full = tok_full;
   assign tok_push = req_push;

   always_comb begin
      tok.ch         = ch;
      tok.last       = req_data.end_of_query;
      tok.is_letter  = is_upper || is_lower;
      tok.is_digit   = ch inside {[8'h30:8'h39]};
      tok.is_space   = (ch == qcp_pkg::CH_SPACE);
      tok.is_newline = (ch == qcp_pkg::CH_NEWLINE);
      tok.is_semi    = (ch == qcp_pkg::CH_SEMI);
      tok.is_quote   = (ch == qcp_pkg::CH_QUOTE);
      tok.is_bslash  = (ch == qcp_pkg::CH_BSLASH);
      tok.lower      = is_upper ? (ch + 8'd32) : ch;
      tok.digit      = ch[3:0];
   end

endmodule

`default_nettype wire

@@ sv/qcp_back.sv @@
// back end: parser state machine, word match, key accumulation, events
// depends on qcp_pkg; reads the token queue and writes the result queue
`default_nettype none

module qcp_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             tok_valid,
   input  wire qcp_pkg::tok_type tok,
   output logic                  tok_pop,
   input  wire logic             rsp_full,
   output logic                  rsp_push,
   output qcp_pkg::rsp_type      rsp
);

   qcp_pkg::phase_type phase_ff, phase_in;
   logic [47:0]        word_letters_ff, word_letters_in;
   logic [2:0]         word_length_ff, word_length_in;
   logic               word_too_long_ff, word_too_long_in;
   logic [63:0]        key_accum_ff, key_accum_in;
   logic               key_overflow_ff, key_overflow_in;
   logic               escape_pending_ff, escape_pending_in;
   logic               finished_ff, finished_in;

   logic               step;
   logic               match_ok;
   qcp_pkg::cmd_type   match_cmd;
   logic               word_full;
   logic [47:0]        word_added;
   logic [63:0]        key_next;
   logic               key_ovf_step;

   assign step     = tok_valid && !rsp_full;
   assign tok_pop  = step;
   assign rsp_push = step;

   // command word lookup
   always_comb begin
      match_ok  = 1'b0;
      match_cmd = qcp_pkg::CMD_SEARCH;
      if (!word_too_long_ff) begin
         if (word_length_ff == 3'd6 && word_letters_ff == qcp_pkg::WORD_SEARCH) begin
            match_ok  = 1'b1;
            match_cmd = qcp_pkg::CMD_SEARCH;
         end else if (word_length_ff == 3'd6 && word_letters_ff == qcp_pkg::WORD_INSERT) begin
            match_ok  = 1'b1;
            match_cmd = qcp_pkg::CMD_INSERT;
         end else if (word_length_ff == 3'd6 && word_letters_ff == qcp_pkg::WORD_DELETE) begin
            match_ok  = 1'b1;
            match_cmd = qcp_pkg::CMD_DELETE;
         end else if (word_length_ff == 3'd4 && word_letters_ff == qcp_pkg::WORD_QUIT) begin
            match_ok  = 1'b1;
            match_cmd = qcp_pkg::CMD_QUIT;
         end
      end
   end

   assign word_full  = (word_length_ff >= 3'd6);
   assign word_added = word_letters_ff | (48'(tok.lower) << {word_length_ff, 3'b000});

   // key * 10 + digit as two shifted adds
   assign key_next = {key_accum_ff[60:0], 3'b000} + {key_accum_ff[62:0], 1'b0}
                   + 64'(tok.digit);
   assign key_ovf_step = (key_accum_ff > qcp_pkg::KEY_LIMIT_DIV)
                      || (key_accum_ff == qcp_pkg::KEY_LIMIT_DIV && tok.digit > 4'd5);

   // result of the current token
   always_comb begin
      rsp.event_res = qcp_pkg::EVT_NONE;
      rsp.cmd       = qcp_pkg::CMD_SEARCH;
      rsp.key_value = '0;
      rsp.data_byte = '0;
      rsp.done_res  = 1'b0;
      rsp.accepted  = 1'b0;
      if (!finished_ff) begin
         case (phase_ff)
            qcp_pkg::PH_EXP_CMD: begin
               if (!(tok.is_space || tok.is_newline || tok.is_letter)) begin
                  rsp.done_res = 1'b1;
               end
            end
            qcp_pkg::PH_RD_CMD: begin
               if (tok.is_letter) begin
               end else if (tok.is_space && match_ok) begin
                  rsp.event_res = qcp_pkg::EVT_CMD;
                  rsp.cmd       = match_cmd;
               end else begin
                  rsp.done_res = 1'b1;
               end
            end
            qcp_pkg::PH_EXP_KEY, qcp_pkg::PH_RD_KEY: begin
               if (tok.is_digit) begin
               end else if (tok.is_space && phase_ff == qcp_pkg::PH_EXP_KEY) begin
               end else if (phase_ff == qcp_pkg::PH_RD_KEY && (tok.is_space || tok.is_semi)) begin
                  if (key_overflow_ff) begin
                     rsp.done_res = 1'b1;
                  end else begin
                     rsp.event_res = qcp_pkg::EVT_KEY;
                     rsp.key_value = key_accum_ff;
                     if (tok.is_semi) begin
                        rsp.done_res = 1'b1;
                        rsp.accepted = 1'b1;
                     end
                  end
               end else begin
                  rsp.done_res = 1'b1;
               end
            end
            qcp_pkg::PH_EXP_PAY: begin
               if (tok.is_space || tok.is_quote) begin
               end else if (tok.is_semi) begin
                  rsp.done_res = 1'b1;
                  rsp.accepted = 1'b1;
               end else begin
                  rsp.done_res = 1'b1;
               end
            end
            qcp_pkg::PH_RD_PAY: begin
               if (escape_pending_ff) begin
                  rsp.event_res = qcp_pkg::EVT_BYTE;
                  rsp.data_byte = tok.ch;
               end else if (tok.is_bslash) begin
               end else if (tok.is_quote) begin
                  rsp.event_res = qcp_pkg::EVT_PEND;
               end else begin
                  rsp.event_res = qcp_pkg::EVT_BYTE;
                  rsp.data_byte = tok.ch;
               end
            end
            default: begin
               rsp.done_res = 1'b1;
            end
         endcase
         if (tok.last) begin
            rsp.done_res = 1'b1;
         end
      end
   end

   // next state
   always_comb begin
      phase_in          = phase_ff;
      word_letters_in   = word_letters_ff;
      word_length_in    = word_length_ff;
      word_too_long_in  = word_too_long_ff;
      key_accum_in      = key_accum_ff;
      key_overflow_in   = key_overflow_ff;
      escape_pending_in = escape_pending_ff;
      finished_in       = finished_ff;
      if (step) begin
         if (!finished_ff) begin
            case (phase_ff)
               qcp_pkg::PH_EXP_CMD, qcp_pkg::PH_RD_CMD: begin
                  if (tok.is_letter && (phase_ff == qcp_pkg::PH_RD_CMD
                                        || !(tok.is_space || tok.is_newline))) begin
                     if (word_full) begin
                        word_too_long_in = 1'b1;
                     end else begin
                        word_letters_in = word_added;
                        word_length_in  = word_length_ff + 3'd1;
                     end
                     phase_in = qcp_pkg::PH_RD_CMD;
                  end else if (phase_ff == qcp_pkg::PH_RD_CMD && tok.is_space && match_ok) begin
                     word_letters_in  = '0;
                     word_length_in   = '0;
                     word_too_long_in = 1'b0;
                     phase_in         = qcp_pkg::PH_EXP_KEY;
                  end
               end
               qcp_pkg::PH_EXP_KEY, qcp_pkg::PH_RD_KEY: begin
                  if (tok.is_digit) begin
                     if (key_ovf_step) begin
                        key_overflow_in = 1'b1;
                     end
                     key_accum_in = key_next;
                     phase_in     = qcp_pkg::PH_RD_KEY;
                  end else if (phase_ff == qcp_pkg::PH_RD_KEY && tok.is_space
                               && !key_overflow_ff) begin
                     phase_in = qcp_pkg::PH_EXP_PAY;
                  end
               end
               qcp_pkg::PH_EXP_PAY: begin
                  if (tok.is_quote) begin
                     phase_in = qcp_pkg::PH_RD_PAY;
                  end
               end
               qcp_pkg::PH_RD_PAY: begin
                  if (escape_pending_ff) begin
                     escape_pending_in = 1'b0;
                  end else if (tok.is_bslash) begin
                     escape_pending_in = 1'b1;
                  end else if (tok.is_quote) begin
                     phase_in = qcp_pkg::PH_EXP_PAY;
                  end
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
            if (rsp.done_res) begin
               finished_in = 1'b1;
            end
         end
         if (tok.last) begin
            phase_in          = qcp_pkg::PH_EXP_CMD;
            word_letters_in   = '0;
            word_length_in    = '0;
            word_too_long_in  = 1'b0;
            key_accum_in      = '0;
            key_overflow_in   = 1'b0;
            escape_pending_in = 1'b0;
            finished_in       = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= qcp_pkg::PH_EXP_CMD;
         word_letters_ff   <= '0;
         word_length_ff    <= '0;
         word_too_long_ff  <= 1'b0;
         key_accum_ff      <= '0;
         key_overflow_ff   <= 1'b0;
         escape_pending_ff <= 1'b0;
         finished_ff       <= 1'b0;
      end else begin
         phase_ff          <= phase_in;
         word_letters_ff   <= word_letters_in;
         word_length_ff    <= word_length_in;
         word_too_long_ff  <= word_too_long_in;
         key_accum_ff      <= key_accum_in;
         key_overflow_ff   <= key_overflow_in;
         escape_pending_ff <= escape_pending_in;
         finished_ff       <= finished_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/query_command_parser.sv @@
// top level of the query command parser: front, token queue, back, result queue
// depends on qcp_pkg, qcp_front, qcp_queue, qcp_back and the assertion macros
//
// usage
// - request side is a queue: drive req_data and raise req_push; a query byte is
//   taken at an edge where req_push is high and req_full is low; end_of_query
//   marks the last byte of a query
// - result side is a queue: while rsp_empty is low the oldest result is on
//   rsp_data; it is taken at an edge where rsp_pop is high
// - every byte gives exactly one result, in order
// - a taken byte is registered in the token queue; the back end then parses it and
//   writes its result into the result queue, from which it can be popped
// - throughput: one byte per cycle while results are popped; the back end's
//   parse step per byte is combinational, with one 64-bit shift-and-add key update
// - the token queue and the result queue, QUEUE_DEPTH entries each, let the
//   front keep taking bytes while a result waits; when the receiver stops
//   popping, both queues fill and req_full rises
// - reset empties both queues and puts the parser in its idle state, waiting
//   for a command word
`default_nettype none
`include "query_command_parser_macros.svh"

module query_command_parser #(
   parameter int QUEUE_DEPTH = qcp_pkg::QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   input  wire qcp_pkg::req_type req_data,
   output logic                  req_full,
   input  wire logic             rsp_pop,
   output qcp_pkg::rsp_type      rsp_data,
   output logic                  rsp_empty
);

   localparam int TOK_W = $bits(qcp_pkg::tok_type);
   localparam int RSP_W = $bits(qcp_pkg::rsp_type);

   qcp_pkg::tok_type front_tok;
   qcp_pkg::tok_type back_tok;
   qcp_pkg::rsp_type back_rsp;
   logic             tok_push, tok_full, tok_empty, tok_pop;
   logic             out_push, out_full;
   logic [TOK_W-1:0] tok_bits;
   logic [RSP_W-1:0] rsp_bits;

   qcp_front u_front (
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .tok_full (tok_full),
      .tok_push (tok_push),
      .tok      (front_tok)
   );

   qcp_queue #(
      .WIDTH (TOK_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_tok_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (tok_push),
      .push_data (front_tok),
      .full      (tok_full),
      .pop       (tok_pop),
      .pop_data  (tok_bits),
      .empty     (tok_empty)
   );

   assign back_tok = qcp_pkg::tok_type'(tok_bits);

   qcp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .tok_valid (!tok_empty),
      .tok       (back_tok),
      .tok_pop   (tok_pop),
      .rsp_full  (out_full),
      .rsp_push  (out_push),
      .rsp       (back_rsp)
   );

   qcp_queue #(
      .WIDTH (RSP_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (back_rsp),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_bits),
      .empty     (rsp_empty)
   );

   assign rsp_data = qcp_pkg::rsp_type'(rsp_bits);

   // one result per token, never more, never fewer
   `QCP_ASSERT_ALWAYS(a_one_result_per_token, clock, reset, tok_pop == out_push)
   // back end only steps on a present token with room for its result
   `QCP_ASSERT_ALWAYS(a_step_has_room, clock, reset, !out_push || (!tok_empty && !out_full))
   // accept only comes with a finish
   `QCP_ASSERT_ALWAYS(a_accept_needs_done, clock, reset,
      rsp_empty || !rsp_data.accepted || rsp_data.done_res)
   // an accepted byte reaches the token queue
   `QCP_ASSERT_NEXT(a_byte_queued, clock, reset, req_push && !req_full, !tok_empty)

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// self-checking testbench for query_command_parser: directed and random queries
// checks every result against its own byte-level parse model; needs qcp_pkg and the rtl
`timescale 1ns / 100ps

module tb;

   localparam int LIMIT_CYCLES = 400000;
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASE_BYTES  = 410;

   class qcp_scoreboard;
      qcp_pkg::phase_type phase;
      logic [47:0] word;
      int unsigned word_len;
      bit          word_long;
      logic [63:0] key_acc;
      bit          key_ovf;
      bit          esc_pending;
      bit          finished;

      qcp_pkg::rsp_type expected_results[$];
      int      bytes_noted;
      int      checked;
      int      mismatches;
      int      accepts;
      int      rejects;
      int      event_count[0:4];

      function new();
         clear_query();
      endfunction

      function void clear_query();
         phase       = qcp_pkg::PH_EXP_CMD;
         word        = '0;
         word_len    = 0;
         word_long   = 0;
         key_acc     = '0;
         key_ovf     = 0;
         esc_pending = 0;
         finished    = 0;
      endfunction

      function void add_letter(logic [7:0] c);
         logic [7:0] lc;
         lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
         if (word_len >= 6) begin
            word_long = 1;
         end else begin
            word[8*word_len +: 8] = lc;
            word_len++;
         end
      endfunction

      function qcp_pkg::rsp_type parse_byte(qcp_pkg::req_type item);
         qcp_pkg::rsp_type r;
         logic [7:0] c;
         logic [3:0] d;
         bit         done;
         bit         acc;
         bit         hit;
         c = item.ch;
         done = 0;
         acc = 0;
         r.event_res = qcp_pkg::EVT_NONE;
         r.cmd = qcp_pkg::CMD_SEARCH;
         r.key_value = '0;
         r.data_byte = '0;
         if (!finished) begin
            case (phase)
               qcp_pkg::PH_EXP_CMD: begin
                  if (c == qcp_pkg::CH_SPACE || c == qcp_pkg::CH_NEWLINE) begin
                  end else if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) begin
                     add_letter(c);
                     phase = qcp_pkg::PH_RD_CMD;
                  end else begin
                     done = 1;
                  end
               end
               qcp_pkg::PH_RD_CMD: begin
                  if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) begin
                     add_letter(c);
                  end else if (c == qcp_pkg::CH_SPACE) begin
                     hit = 1;
                     if (word_long) hit = 0;
                     else if (word_len == 6 && word == qcp_pkg::WORD_SEARCH)
                        r.cmd = qcp_pkg::CMD_SEARCH;
                     else if (word_len == 6 && word == qcp_pkg::WORD_INSERT)
                        r.cmd = qcp_pkg::CMD_INSERT;
                     else if (word_len == 6 && word == qcp_pkg::WORD_DELETE)
                        r.cmd = qcp_pkg::CMD_DELETE;
                     else if (word_len == 4 && word == qcp_pkg::WORD_QUIT)
                        r.cmd = qcp_pkg::CMD_QUIT;
                     else hit = 0;
                     if (!hit) begin
                        r.cmd = qcp_pkg::CMD_SEARCH;
                        done = 1;
                     end else begin
                        r.event_res = qcp_pkg::EVT_CMD;
                        word = '0;
                        word_len = 0;
                        word_long = 0;
                        phase = qcp_pkg::PH_EXP_KEY;
                     end
                  end else begin
                     done = 1;
                  end
               end
               qcp_pkg::PH_EXP_KEY, qcp_pkg::PH_RD_KEY: begin
                  if (c >= "0" && c <= "9") begin
                     d = 4'(c - 8'h30);
                     if (key_acc > qcp_pkg::KEY_LIMIT_DIV
                         || (key_acc == qcp_pkg::KEY_LIMIT_DIV && d > 4'd5))
                        key_ovf = 1;
                     key_acc = key_acc * 64'd10 + 64'(d);
                     phase = qcp_pkg::PH_RD_KEY;
                  end else if (c == qcp_pkg::CH_SPACE && phase == qcp_pkg::PH_EXP_KEY) begin
                  end else if (phase == qcp_pkg::PH_RD_KEY
                               && (c == qcp_pkg::CH_SPACE || c == qcp_pkg::CH_SEMI)) begin
                     if (key_ovf) begin
                        done = 1;
                     end else begin
                        r.event_res = qcp_pkg::EVT_KEY;
                        r.key_value = key_acc;
                        if (c == qcp_pkg::CH_SEMI) begin
                           done = 1;
                           acc = 1;
                        end else begin
                           phase = qcp_pkg::PH_EXP_PAY;
                        end
                     end
                  end else begin
                     done = 1;
                  end
               end
               qcp_pkg::PH_EXP_PAY: begin
                  if (c == qcp_pkg::CH_SPACE) begin
                  end else if (c == qcp_pkg::CH_QUOTE) begin
                     phase = qcp_pkg::PH_RD_PAY;
                  end else if (c == qcp_pkg::CH_SEMI) begin
                     done = 1;
                     acc = 1;
                  end else begin
                     done = 1;
                  end
               end
               qcp_pkg::PH_RD_PAY: begin
                  if (esc_pending) begin
                     esc_pending = 0;
                     r.event_res = qcp_pkg::EVT_BYTE;
                     r.data_byte = c;
                  end else if (c == qcp_pkg::CH_BSLASH) begin
                     esc_pending = 1;
                  end else if (c == qcp_pkg::CH_QUOTE) begin
                     r.event_res = qcp_pkg::EVT_PEND;
                     phase = qcp_pkg::PH_EXP_PAY;
                  end else begin
                     r.event_res = qcp_pkg::EVT_BYTE;
                     r.data_byte = c;
                  end
               end
               default: begin
                  done = 1;
               end
            endcase
            if (item.end_of_query) done = 1;
            if (done) finished = 1;
         end
         if (item.end_of_query) clear_query();
         r.done_res = done;
         r.accepted = done && acc;
         return r;
      endfunction

      function void note_byte(qcp_pkg::req_type item);
         qcp_pkg::rsp_type r;
         r = parse_byte(item);
         expected_results.insert(expected_results.size(), r);
         bytes_noted++;
         event_count[r.event_res]++;
         if (r.done_res) begin
            if (r.accepted) accepts++;
            else rejects++;
         end
      endfunction

      task report_mismatch(string what, logic [78:0] got_v, logic [78:0] want_v);
         mismatches++;
         $display("mismatch at result %0d: %s got %0h expected %0h",
                  checked, what, got_v, want_v);
      endtask

      task check_result(qcp_pkg::rsp_type got);
         qcp_pkg::rsp_type want;
         checked++;
         if (expected_results.size() == 0) begin
            report_mismatch("result with nothing expected", got, '0);
            return;
         end
         want = expected_results.pop_front();
         if (got.event_res !== want.event_res)
            report_mismatch("event_res", got.event_res, want.event_res);
         if (got.cmd !== want.cmd)
            report_mismatch("cmd", got.cmd, want.cmd);
         if (got.key_value !== want.key_value)
            report_mismatch("key_value", got.key_value, want.key_value);
         if (got.data_byte !== want.data_byte)
            report_mismatch("data_byte", got.data_byte, want.data_byte);
         if (got.done_res !== want.done_res)
            report_mismatch("done_res", got.done_res, want.done_res);
         if (got.accepted !== want.accepted)
            report_mismatch("accepted", got.accepted, want.accepted);
      endtask
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_push = 1'b0;
   qcp_pkg::req_type req_data = '0;
   logic             req_full;
   logic             rsp_pop = 1'b0;
   qcp_pkg::rsp_type rsp_data;
   logic             rsp_empty;

   qcp_scoreboard sb = new();
   logic [7:0]    query_bytes[$];
   int            queries_sent;
   int            send_idle_pct = 25;
   int            take_idle_pct = 77;
   bit            hold_request;
   int            hold_left;

   query_command_parser i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .rsp_empty (rsp_empty)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #(2 * LIMIT_CYCLES);
      $display("query_command_parser regression: fail");
      $finish;
   end

   // receiver: random pops, plus one long hold-off per request
   initial begin
      forever begin
         if (hold_left == 0 && hold_request) begin
            hold_request = 0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(99) >= take_idle_pct);
         end
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) sb.check_result(rsp_data);
      end
   end

   function void add_byte(logic [7:0] b);
      query_bytes.insert(query_bytes.size(), b);
   endfunction

   task push_byte(qcp_pkg::req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_full) @(posedge clock);
      sb.note_byte(item);
   endtask

   task send_query();
      for (int i = 0; i < query_bytes.size(); i++)
         push_byte(qcp_pkg::req_type'{ch: query_bytes[i],
                                      end_of_query: (i == query_bytes.size() - 1)});
      query_bytes.delete();
      queries_sent++;
   endtask

   function void put_text(string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endfunction

   task send_text(string s);
      put_text(s);
      send_query();
   endtask

   function void build_random_query();
      string       w;
      logic [63:0] k;
      logic [7:0]  b;
      int          mode;
      int          len;
      int          cut;
      mode = $urandom_range(99);
      if (mode < 8) begin
         repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(255)));
         return;
      end
      repeat ($urandom_range(3))
         add_byte($urandom_range(1) ? qcp_pkg::CH_SPACE : qcp_pkg::CH_NEWLINE);
      case ($urandom_range(3))
         0: w = "search";
         1: w = "insert";
         2: w = "delete";
         default: w = "quit";
      endcase
      len = w.len();
      if (mode >= 88 && mode < 94) len = len - 1;
      for (int i = 0; i < len; i++) begin
         b = w[i];
         if ($urandom_range(1)) b = b - 8'd32;
         add_byte(b);
      end
      if (mode >= 94)
         repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(122, 97)));
      repeat ($urandom_range(1, 3)) add_byte(qcp_pkg::CH_SPACE);
      // key text, from short values to beyond 64 bits
      case ($urandom_range(5))
         0: put_text($sformatf("%0d", $urandom_range(999)));
         1: begin
            k = {$urandom, $urandom};
            put_text($sformatf("%0d", k));
         end
         2: put_text("18446744073709551615");
         3: put_text($sformatf("1844674407370955161%0d", $urandom_range(9)));
         4: repeat ($urandom_range(20, 22)) add_byte(8'($urandom_range(57, 48)));
         default: put_text($sformatf("000%0d", $urandom_range(99)));
      endcase
      if ($urandom_range(3) == 0) begin
         add_byte(qcp_pkg::CH_SEMI);
      end else begin
         repeat ($urandom_range(1, 2)) add_byte(qcp_pkg::CH_SPACE);
         repeat ($urandom_range(3)) begin
            add_byte(qcp_pkg::CH_QUOTE);
            repeat ($urandom_range(5)) begin
               if ($urandom_range(4) == 0) begin
                  add_byte(qcp_pkg::CH_BSLASH);
                  add_byte(8'($urandom_range(255)));
               end else begin
                  do b = 8'($urandom_range(255));
                  while (b == qcp_pkg::CH_QUOTE || b == qcp_pkg::CH_BSLASH);
                  add_byte(b);
               end
            end
            add_byte(qcp_pkg::CH_QUOTE);
            repeat ($urandom_range(1)) add_byte(qcp_pkg::CH_SPACE);
         end
         add_byte(qcp_pkg::CH_SEMI);
      end
      if ($urandom_range(3) == 0)
         repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(255)));
      // damaged queries: one byte replaced, or cut short
      if ($urandom_range(7) == 0)
         query_bytes[$urandom_range(query_bytes.size() - 1)] = 8'($urandom_range(255));
      if ($urandom_range(9) == 0) begin
         cut = $urandom_range(1, query_bytes.size());
         while (query_bytes.size() > cut) void'(query_bytes.pop_back());
      end
   endfunction

   initial begin
      int stop;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_text("quit 0;");
      send_text(" \n\nDeLeTe 18446744073709551615 \"\\\\x\\\"\" \"\";");
      put_text("SEARCH 00012 \"");
      add_byte(8'h00);
      add_byte(8'hFF);
      put_text("\";");
      send_query();
      send_text("searchx 1;");
      send_text("quiz 1;");
      send_text("quit;");
      send_text("search  18446744073709551616;");
      send_text("insert 5 \"ab\\");
      send_text("insert 12");
      send_text("delete 3 x;");
      send_text("quit 9; junk");
      send_text("#");

      for (int p = 0; p < 3; p++) begin
         case (p)
            0: begin send_idle_pct = 25; take_idle_pct = 77; end
            1: begin send_idle_pct = 77; take_idle_pct = 25; end
            default: begin send_idle_pct = 0; take_idle_pct = 0; end
         endcase
         hold_request = 1;
         stop = sb.bytes_noted + PHASE_BYTES;
         while (sb.bytes_noted < stop) begin
            build_random_query();
            send_query();
         end
      end
      req_push <= 1'b0;

      while (sb.expected_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("covered %0d queries in %0d transactions: %0d accepted, %0d rejected",
               queries_sent, sb.bytes_noted, sb.accepts, sb.rejects);
      $display("events: %0d commands, %0d keys, %0d payload bytes, %0d payload ends",
               sb.event_count[qcp_pkg::EVT_CMD], sb.event_count[qcp_pkg::EVT_KEY],
               sb.event_count[qcp_pkg::EVT_BYTE], sb.event_count[qcp_pkg::EVT_PEND]);
      if (sb.mismatches == 0) begin
         $display("query_command_parser regression: pass");
      end else begin
         $display("query_command_parser regression: fail");
      end
      $finish;
   end

endmodule
